FILE: rtl/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants of the RDS block bit encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

    localparam int BLOCK_BITS = 26;
    localparam int INFO_BITS  = 16;
    localparam int CHECK_BITS = 10;
    localparam int CNT_W      = 5;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BLOCK_BITS - 1);

    // Block kind codes
    localparam logic [2:0] KIND_A       = 3'd0;
    localparam logic [2:0] KIND_B       = 3'd1;
    localparam logic [2:0] KIND_C       = 3'd2;
    localparam logic [2:0] KIND_D       = 3'd3;
    localparam logic [2:0] KIND_C_PRIME = 3'd4;

    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [CHECK_BITS-1:0] check_t;

    typedef struct packed {
        logic [15:0] info_word;
        logic [2:0]  block_kind;
    } in_word_t;

    typedef struct packed {
        logic       coded_bit;
        logic [2:0] symbol_index;
        logic       last_bit;
    } out_word_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Remainder of x^(10+i) mod g(x), g = x^10+x^8+x^7+x^5+x^4+x^3+1
    localparam check_t SYNDROME [INFO_BITS] = '{
        10'h1B9, 10'h372, 10'h35D, 10'h303, 10'h3BF, 10'h2C7, 10'h037, 10'h06E,
        10'h0DC, 10'h1B8, 10'h370, 10'h359, 10'h30B, 10'h3AF, 10'h2E7, 10'h077
    };

    function automatic check_t kind_offset(input logic [2:0] kind);
        check_t ow;
        unique case (kind)
            KIND_A:       ow = 10'h0FC;
            KIND_B:       ow = 10'h198;
            KIND_C:       ow = 10'h168;
            KIND_D:       ow = 10'h1B4;
            KIND_C_PRIME: ow = 10'h350;
            default:      ow = '0;
        endcase
        return ow;
    endfunction

    // Checkword is linear in the info bits: XOR the syndrome of each set bit
    function automatic check_t checkword(input logic [15:0] info);
        check_t acc;
        acc = '0;
        for (int i = 0; i < INFO_BITS; i++) begin
            if (info[i])
            begin
                acc = acc ^ SYNDROME[i];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rbe_front.sv
// ----------------------------------------------------------------------------
// rbe_front
// Accept words, form the 26-bit block with checkword and offset, hand to queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rbe_pkg::in_word_t item,
    output logic                   full,
    output logic                   q_push,
    output rbe_pkg::block_t        q_data,
    input  wire logic              q_full
);
    import rbe_pkg::*;

    logic   valid_reg, valid_next;
    block_t block_reg, block_next;
    logic   take;

    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign take   = push && !full;
    assign q_data = block_reg;

    always_comb
    begin
        valid_next = valid_reg;
        block_next = block_reg;
        if (take)
        begin
            valid_next = 1'b1;
            block_next = {item.info_word,
                          checkword(item.info_word) ^ kind_offset(item.block_kind)};
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

endmodule

`default_nettype wire

FILE: rtl/rbe_queue.sv
// ----------------------------------------------------------------------------
// rbe_queue
// Short register queue of encoded blocks between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire rbe_pkg::block_t    wr_data,
    input  wire logic               rd_en,
    output rbe_pkg::block_t         rd_data,
    output rbe_pkg::q_status_t      status
);
    import rbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    block_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CNT_FULL);
    assign do_wr   = wr_en && !status.full;
    assign do_rd   = rd_en && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rbe_back.sv
// ----------------------------------------------------------------------------
// rbe_back
// Shift the block out MSB first, differential coding, symbol window, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rbe_pkg::q_status_t  q_status,
    input  wire rbe_pkg::block_t     q_data,
    output logic                     q_pop,
    output logic                     empty,
    input  wire logic                pop,
    output rbe_pkg::out_word_t       result
);
    import rbe_pkg::*;

    logic             busy_reg, busy_next;
    block_t           shift_reg, shift_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       win_reg, win_next;
    logic             ovalid_reg, ovalid_next;
    out_word_t        out_reg, out_next;

    block_t           cur_block;
    logic [CNT_W-1:0] cur_cnt;
    logic             advance, emit, coded;

    // Take the first bit straight from the queue head: no bubble between blocks
    assign cur_block = busy_reg ? shift_reg : q_data;
    assign cur_cnt   = busy_reg ? cnt_reg : '0;
    assign advance   = !ovalid_reg || pop;
    assign emit      = advance && (busy_reg || !q_status.empty);
    assign q_pop     = emit && !busy_reg;
    assign coded     = cur_block[BLOCK_BITS-1] ^ win_reg[0];
    assign empty     = !ovalid_reg;
    assign result    = out_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        win_next    = win_reg;
        ovalid_next = ovalid_reg;
        out_next    = out_reg;
        if (emit)
        begin
            shift_next            = cur_block << 1;
            cnt_next              = cur_cnt + 1'b1;
            busy_next             = (cur_cnt != LAST_CNT);
            win_next              = {win_reg[1:0], coded};
            ovalid_next           = 1'b1;
            out_next.coded_bit    = coded;
            out_next.symbol_index = {win_reg[1:0], coded};
            out_next.last_bit     = (cur_cnt == LAST_CNT);
        end
        else if (advance)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            win_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            win_reg    <= win_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

FILE: rtl/rds_block_bit_encoder.sv
// Path: a pushed word goes through the front register and the queue to the output
// register. One result per cycle while results are popped; a word is 26 bits in the
// bit serializer of the back end, and words follow each other without a gap.
// Reset: rst_n asynchronous, active low; clears the queue, serializer state and
// the symbol window to zero. No clearing pass; words are taken right after reset.
// ----------------------------------------------------------------------------
// rds_block_bit_encoder
// RDS checkword/offset encoder with differential coding and biphase window.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_block_bit_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rbe_pkg::in_word_t  item,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output rbe_pkg::out_word_t      result
);
    import rbe_pkg::*;

    // Front end -> queue
    logic      q_push;
    block_t    q_wr_data;
    // Queue -> back end
    block_t    q_rd_data;
    q_status_t q_status;
    logic      q_pop;

    // Front: register the incoming word and its complete 26-bit block.
    // Checkword is the XOR of per-bit syndromes, then the offset word is folded in.
    rbe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wr_data),
        .q_full (q_status.full)
    );

    // Queue: decouple block forming from serialization so either side can stall.
    rbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // Back: shift the block out MSB first, code each bit against the previous
    // coded bit and advance the 3-bit symbol window; the window carries across
    // blocks. The output register holds the word until popped.
    rbe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_rd_data),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // Newest window bit is the coded bit shown with it
    a_window_newest: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.symbol_index[0] == result.coded_bit))
        else $error("symbol window newest bit differs from coded bit");

    // Consecutive results shift the window by one
    a_window_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) ##1 !empty |->
            (result.symbol_index[2:1] == $past(result.symbol_index[1:0])))
        else $error("symbol window did not shift between results");

    // Back pressure only comes from a held front word over a full queue
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_status.full)
        else $error("full raised while queue has room");

    // Queue never read when empty
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire
